// ===== sv/cprd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprd_pkg
// Shared types and fixed widths of the primary ray direction pipeline.
// ----------------------------------------------------------------------------
package cprd_pkg;

  localparam int DIM_W      = 13;
  localparam int TAN_W      = 24;
  localparam int AXIS_W     = 16;
  localparam int AXES_W     = 3 * AXIS_W;
  localparam int POS_W      = 16;
  localparam int OUT_W      = 16;
  localparam int NORM_W     = 30;
  localparam int ANGLE_FRAC = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_IMAGE_HEIGHT   = 3'd1,
    CFG_TAN_HALF_FOV_X = 3'd2,
    CFG_TAN_HALF_FOV_Y = 3'd3,
    CFG_RIGHT_AXIS     = 3'd4,
    CFG_UP_AXIS        = 3'd5,
    CFG_BACK_AXIS      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                          zero;
    logic [2:0]                    neg;
    logic [2:0][NORM_W-1:0]        mag;
  } root_tag_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } comp_tag_t;

endpackage

// ===== sv/cprd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprd_in_if
// Image-plane position channel.
// ----------------------------------------------------------------------------
interface cprd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_pos;
  logic [15:0] y_pos;

  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

// ===== sv/cprd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprd_out_if
// Unit ray direction channel.
// ----------------------------------------------------------------------------
interface cprd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ===== sv/cprd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprd_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// tag. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module cprd_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  localparam int EW = (NW > DW + QW) ? NW : DW + QW;

  logic [EW-1:0] rem_q [1:QW];
  logic [DW-1:0] den_q [1:QW];
  logic [QW-1:0] quo_q [1:QW];
  logic [TW-1:0] tag_q [1:QW];
  logic          vld_q [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [EW-1:0] src_rem;
    logic [DW-1:0] src_den;
    logic [QW-1:0] src_quo;
    logic [TW-1:0] src_tag;
    logic          src_vld;
    logic [EW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign src_rem = EW'(num_i);
      assign src_den = den_i;
      assign src_quo = '0;
      assign src_tag = tag_i;
      assign src_vld = valid_i;
    end else begin : g_next
      assign src_rem = rem_q[s];
      assign src_den = den_q[s];
      assign src_quo = quo_q[s];
      assign src_tag = tag_q[s];
      assign src_vld = vld_q[s];
    end

    assign trial = EW'(src_den) << (QW - 1 - s);
    assign ge    = src_rem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? src_rem - trial : src_rem;
        den_q[s+1] <= src_den;
        quo_q[s+1] <= src_quo | (QW'(ge) << (QW - 1 - s));
        tag_q[s+1] <= src_tag;
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = quo_q[QW];
  assign tag_o   = tag_q[QW];

endmodule

// ===== sv/cprd_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprd_norm
// Common left normalization of three magnitudes, one power-of-two shift per
// stage, leaving the top NORM_W bits of each.
// ----------------------------------------------------------------------------
module cprd_norm
  import cprd_pkg::*;
#(
  parameter int W  = 48,
  parameter int TW = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [2:0][W-1:0]      mag_i,
  input  logic [TW-1:0]          tag_i,
  output logic                   valid_o,
  output logic [2:0][NORM_W-1:0] mag_o,
  output logic                   zero_o,
  output logic [TW-1:0]          tag_o
);

  localparam int NS = $clog2(W);

  logic [2:0][W-1:0] mag_q [1:NS];
  logic [TW-1:0]     tag_q [1:NS];
  logic              vld_q [1:NS];
  logic [W-1:0]      fin_or;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int SH = 1 << (NS - 1 - s);
    logic [2:0][W-1:0] src_mag;
    logic [TW-1:0]     src_tag;
    logic              src_vld;
    logic [W-1:0]      orw;
    logic              shift;

    if (s == 0) begin : g_first
      assign src_mag = mag_i;
      assign src_tag = tag_i;
      assign src_vld = valid_i;
    end else begin : g_next
      assign src_mag = mag_q[s];
      assign src_tag = tag_q[s];
      assign src_vld = vld_q[s];
    end

    assign orw   = src_mag[0] | src_mag[1] | src_mag[2];
    assign shift = orw[W-1 -: SH] == '0;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < 3; k++) begin
          mag_q[s+1][k] <= shift ? src_mag[k] << SH : src_mag[k];
        end
        tag_q[s+1] <= src_tag;
      end
    end
  end

  assign fin_or  = mag_q[NS][0] | mag_q[NS][1] | mag_q[NS][2];
  assign zero_o  = fin_or == '0;
  assign valid_o = vld_q[NS];
  assign tag_o   = tag_q[NS];

  for (genvar k = 0; k < 3; k++) begin : g_out
    assign mag_o[k] = mag_q[NS][k][W-1 -: NORM_W];
  end

endmodule

// ===== sv/cprd_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprd_isqrt
// Pipelined integer square root, one root bit per stage, with a sideband tag.
// ----------------------------------------------------------------------------
module cprd_isqrt #(
  parameter int IW = 62,
  parameter int TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [IW-1:0]   rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [IW/2-1:0] root_o,
  output logic [TW-1:0]   tag_o
);

  localparam int NB = IW / 2;
  localparam int VW = IW + 1;

  logic [VW-1:0] v_q   [1:NB];
  logic [VW-1:0] res_q [1:NB];
  logic [TW-1:0] tag_q [1:NB];
  logic          vld_q [1:NB];

  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [VW-1:0] src_v;
    logic [VW-1:0] src_res;
    logic [TW-1:0] src_tag;
    logic          src_vld;
    logic [VW-1:0] bitv;
    logic [VW-1:0] sum;
    logic          ge;

    if (s == 0) begin : g_first
      assign src_v   = VW'(rad_i);
      assign src_res = '0;
      assign src_tag = tag_i;
      assign src_vld = valid_i;
    end else begin : g_next
      assign src_v   = v_q[s];
      assign src_res = res_q[s];
      assign src_tag = tag_q[s];
      assign src_vld = vld_q[s];
    end

    assign bitv = VW'(1) << (IW - 2 - 2 * s);
    assign sum  = src_res + bitv;
    assign ge   = src_v >= sum;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s+1]   <= ge ? src_v - sum : src_v;
        res_q[s+1] <= ge ? (src_res >> 1) + bitv : src_res >> 1;
        tag_q[s+1] <= src_tag;
      end
    end
  end

  assign valid_o = vld_q[NB];
  assign root_o  = res_q[NB][NB-1:0];
  assign tag_o   = tag_q[NB];

endmodule

// ===== sv/camera_primary_ray_direction.sv =====
`timescale 1ns / 1ps
// Pipeline at the default formats: two 37-stage offset dividers, a 6-stage
// normalizer, a 31-stage square root, 15-stage output dividers and eleven
// stages of registers around them.
// Throughput: one transaction per cycle while the skid register is empty; an output
// skid register takes a stalled result and the pipeline holds while it is full. Reset
// clears all valid bits and loads the default camera: 640x480 image, u = x, v = y, w = z.
// ----------------------------------------------------------------------------
// camera_primary_ray_direction
// Pinhole camera primary ray direction: image position in, unit direction out.
// ----------------------------------------------------------------------------
module camera_primary_ray_direction
  import cprd_pkg::*;
#(
  parameter int DIR_FRAC_BITS   = 14,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [AXES_W-1:0]    cfg_data_i,
  cprd_in_if.sink              in_i,
  cprd_out_if.source           out_o
);

  localparam int CF   = COORD_FRAC_BITS;
  localparam int DF   = DIR_FRAC_BITS;
  localparam int MW   = (POS_W + 1 > DIM_W + CF) ? POS_W + 1 : DIM_W + CF;
  localparam int PW   = TAN_W + MW;
  localparam int DENW = DIM_W + CF;
  localparam int ANW  = PW + 2;
  localparam int ADW  = DENW + 1;
  localparam int AQW  = (TAN_W + POS_W + 1 - CF > TAN_W + 1) ?
                        TAN_W + POS_W + 1 - CF : TAN_W + 1;
  localparam int AW   = AQW + 1;
  localparam int PRW  = AW + AXIS_W;
  localparam int DSW  = PRW + 2;
  localparam int SQW  = 2 * NORM_W;
  localparam int SUMW = SQW + 2;
  localparam int RTW  = SUMW / 2;
  localparam int FQW  = DF + 1;
  localparam int FNW  = NORM_W + FQW + 1;
  localparam int FDW  = RTW + 1;
  localparam int OXW  = (FQW + 1 > OUT_W) ? FQW + 1 : OUT_W;

  // configuration
  logic [DIM_W-1:0]  cfg_w_q, cfg_h_q;
  logic [TAN_W-1:0]  cfg_tx_q, cfg_ty_q;
  logic [AXES_W-1:0] cfg_u_q, cfg_v_q, cfg_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= DIM_W'(640);
      cfg_h_q  <= DIM_W'(480);
      cfg_tx_q <= TAN_W'(87381);
      cfg_ty_q <= TAN_W'(65536);
      cfg_u_q  <= AXES_W'(48'h0000_0000_4000);
      cfg_v_q  <= AXES_W'(48'h0000_4000_0000);
      cfg_b_q  <= AXES_W'(48'h4000_0000_0000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:    cfg_w_q  <= cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:   cfg_h_q  <= cfg_data_i[DIM_W-1:0];
        CFG_TAN_HALF_FOV_X: cfg_tx_q <= cfg_data_i[TAN_W-1:0];
        CFG_TAN_HALF_FOV_Y: cfg_ty_q <= cfg_data_i[TAN_W-1:0];
        CFG_RIGHT_AXIS:     cfg_u_q  <= cfg_data_i;
        CFG_UP_AXIS:        cfg_v_q  <= cfg_data_i;
        CFG_BACK_AXIS:      cfg_b_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [AXIS_W-1:0] uc [3];
  logic signed [AXIS_W-1:0] vc [3];
  logic signed [AXIS_W-1:0] bc [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign uc[k] = cfg_u_q[AXIS_W*k +: AXIS_W];
    assign vc[k] = cfg_v_q[AXIS_W*k +: AXIS_W];
    assign bc[k] = cfg_b_q[AXIS_W*k +: AXIS_W];
  end

  // global advance: hold while the skid register is occupied
  logic sk_v_q;
  logic en;
  assign en         = !sk_v_q;
  assign in_i.ready = en;

  // stage 0: offsets from the image centre
  logic [DIM_W-1:0] wdim, hdim;
  logic [DENW-1:0]  wd, hd;
  logic [MW:0]      twox, twoy, wdx, hdx;
  logic             negx_d, negy_d;
  logic [MW-1:0]    magx_d, magy_d;

  assign wdim   = (cfg_w_q == '0) ? DIM_W'(1) : cfg_w_q;
  assign hdim   = (cfg_h_q == '0) ? DIM_W'(1) : cfg_h_q;
  assign wd     = DENW'(wdim) << CF;
  assign hd     = DENW'(hdim) << CF;
  assign twox   = (MW + 1)'({in_i.x_pos, 1'b0});
  assign twoy   = (MW + 1)'({in_i.y_pos, 1'b0});
  assign wdx    = (MW + 1)'(wd);
  assign hdx    = (MW + 1)'(hd);
  assign negx_d = twox < wdx;
  assign negy_d = hdx < twoy;
  assign magx_d = negx_d ? MW'(wdx - twox) : MW'(twox - wdx);
  assign magy_d = negy_d ? MW'(twoy - hdx) : MW'(hdx - twoy);

  logic            v0_q, v1_q, v2_q;
  logic [MW-1:0]   magx0_q, magy0_q;
  logic            negx0_q, negy0_q, negx1_q, negy1_q, negx2_q, negy2_q;
  logic [DENW-1:0] denx0_q, deny0_q, denx1_q, deny1_q;
  logic [PW-1:0]   px1_q, py1_q;
  logic [ANW-1:0]  numx2_q, numy2_q;
  logic [ADW-1:0]  dvx2_q, dvy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      magx0_q <= magx_d;
      magy0_q <= magy_d;
      negx0_q <= negx_d;
      negy0_q <= negy_d;
      denx0_q <= wd;
      deny0_q <= hd;
      px1_q   <= PW'(cfg_tx_q) * PW'(magx0_q);
      py1_q   <= PW'(cfg_ty_q) * PW'(magy0_q);
      negx1_q <= negx0_q;
      negy1_q <= negy0_q;
      denx1_q <= denx0_q;
      deny1_q <= deny0_q;
      numx2_q <= ANW'({px1_q, 1'b0}) + ANW'(denx1_q);
      numy2_q <= ANW'({py1_q, 1'b0}) + ANW'(deny1_q);
      dvx2_q  <= {denx1_q, 1'b0};
      dvy2_q  <= {deny1_q, 1'b0};
      negx2_q <= negx1_q;
      negy2_q <= negy1_q;
    end
  end

  // alpha and beta
  logic           va_o, vb_o;
  logic [AQW-1:0] qa, qb;
  logic           ta, tb;

  cprd_div #(.NW(ANW), .DW(ADW), .QW(AQW), .TW(1)) u_div_alpha (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .num_i(numx2_q), .den_i(dvx2_q),
    .tag_i(negx2_q), .valid_o(va_o), .quo_o(qa), .tag_o(ta)
  );

  cprd_div #(.NW(ANW), .DW(ADW), .QW(AQW), .TW(1)) u_div_beta (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2_q), .num_i(numy2_q), .den_i(dvy2_q),
    .tag_i(negy2_q), .valid_o(vb_o), .quo_o(qb), .tag_o(tb)
  );

  // stages 3..6: direction before normalization
  logic                  v3_q, v4_q, v5_q, v6_q;
  logic signed [AW-1:0]  alpha3_q, beta3_q;
  logic signed [PRW-1:0] pu4_q [3];
  logic signed [PRW-1:0] pv4_q [3];
  logic signed [DSW-1:0] d5_q  [3];
  logic [2:0][DSW-1:0]   mag6_q;
  logic [2:0]            neg6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha3_q <= ta ? AW'(0) - AW'(qa) : AW'(qa);
      beta3_q  <= tb ? AW'(0) - AW'(qb) : AW'(qb);
      for (int k = 0; k < 3; k++) begin
        pu4_q[k]  <= PRW'(alpha3_q) * PRW'(uc[k]);
        pv4_q[k]  <= PRW'(beta3_q) * PRW'(vc[k]);
        d5_q[k]   <= DSW'(pu4_q[k]) + DSW'(pv4_q[k]) - (DSW'(bc[k]) <<< ANGLE_FRAC);
        neg6_q[k] <= d5_q[k][DSW-1];
        mag6_q[k] <= d5_q[k][DSW-1] ? DSW'(0) - DSW'(d5_q[k]) : DSW'(d5_q[k]);
      end
    end
  end

  // normalization
  logic                   vn_o, zn_o;
  logic [2:0][NORM_W-1:0] mn_o;
  logic [2:0]             nn_o;

  cprd_norm #(.W(DSW), .TW(3)) u_norm (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .mag_i(mag6_q), .tag_i(neg6_q),
    .valid_o(vn_o), .mag_o(mn_o), .zero_o(zn_o), .tag_o(nn_o)
  );

  // stages 7, 8: sum of squares
  logic                   v7_q, v8_q;
  logic [SQW-1:0]         sq7_q [3];
  root_tag_t              t7_q, t8_q;
  logic [SUMW-1:0]        sum8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq7_q[k] <= SQW'(mn_o[k]) * SQW'(mn_o[k]);
      end
      t7_q.zero <= zn_o;
      t7_q.neg  <= nn_o;
      t7_q.mag  <= mn_o;
      sum8_q    <= SUMW'(sq7_q[0]) + SUMW'(sq7_q[1]) + SUMW'(sq7_q[2]);
      t8_q      <= t7_q;
    end
  end

  logic           vr_o;
  logic [RTW-1:0] len;
  root_tag_t      tr_o;

  cprd_isqrt #(.IW(SUMW), .TW($bits(root_tag_t))) u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v8_q), .rad_i(sum8_q), .tag_i(t8_q),
    .valid_o(vr_o), .root_o(len), .tag_o(tr_o)
  );

  // stage 9: final division operands
  logic           v9_q;
  logic [FNW-1:0] fn9_q [3];
  logic [FDW-1:0] fd9_q;
  comp_tag_t      ct9_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fd9_q <= {len, 1'b0};
      for (int k = 0; k < 3; k++) begin
        fn9_q[k]      <= (FNW'(tr_o.mag[k]) << FQW) + FNW'(len);
        ct9_q[k].zero <= tr_o.zero;
        ct9_q[k].neg  <= tr_o.neg[k];
      end
    end
  end

  logic [2:0]     vf_o;
  logic [FQW-1:0] qf [3];
  comp_tag_t      cf_o [3];

  for (genvar k = 0; k < 3; k++) begin : g_fdiv
    cprd_div #(.NW(FNW), .DW(FDW), .QW(FQW), .TW($bits(comp_tag_t))) u_div_comp (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v9_q), .num_i(fn9_q[k]), .den_i(fd9_q),
      .tag_i(ct9_q[k]), .valid_o(vf_o[k]), .quo_o(qf[k]), .tag_o(cf_o[k])
    );
  end

  // stage 10: limit, sign, output register
  logic [OUT_W-1:0] res_d [3];
  logic [OUT_W-1:0] res_q [3];
  logic             vo_q;

  for (genvar k = 0; k < 3; k++) begin : g_res
    logic [FQW-1:0] lim;
    logic [FQW-1:0] ql;
    logic [OXW-1:0] qx;
    assign lim      = FQW'(1) << DF;
    assign ql       = (qf[k] > lim) ? lim : qf[k];
    assign qx       = OXW'(ql);
    assign res_d[k] = cf_o[k].zero ? '0 :
                      cf_o[k].neg ? OUT_W'(OXW'(0) - qx) : OUT_W'(qx);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        res_q[k] <= res_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= va_o & vb_o;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= vn_o;
      v8_q <= v7_q;
      v9_q <= vr_o;
      vo_q <= &vf_o;
    end
  end

  // skid register: take the stalled result so the pipeline can advance once
  logic [OUT_W-1:0] sk_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_v_q <= 1'b0;
    end else if (sk_v_q) begin
      if (out_o.ready) begin
        sk_v_q <= 1'b0;
      end
    end else if (vo_q && !out_o.ready) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sk_v_q && vo_q && !out_o.ready) begin
      for (int k = 0; k < 3; k++) begin
        sk_q[k] <= res_q[k];
      end
    end
  end

  assign out_o.valid = sk_v_q | vo_q;
  assign out_o.dir_x = sk_v_q ? sk_q[0] : res_q[0];
  assign out_o.dir_y = sk_v_q ? sk_q[1] : res_q[1];
  assign out_o.dir_z = sk_v_q ? sk_q[2] : res_q[2];

endmodule
